@@ rtl/crp_pkg.sv @@
// ----------------------------------------------------------------------------
// crp_pkg
// Types and constants shared by the crop and rotate pixel scatter block.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = CNT_W + 1;
    localparam int COLOR_W    = 8;
    localparam int INDEX_W    = 20;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CROP_TOP     = 3'd2,
        REG_CROP_LEFT    = 3'd3,
        REG_CROP_BOTTOM  = 3'd4,
        REG_CROP_RIGHT   = 3'd5,
        REG_ROTATION     = 3'd6
    } crp_reg_t;

    typedef enum logic [1:0] {
        ROT_NONE    = 2'd0,
        ROT_QUARTER = 2'd1,
        ROT_HALF    = 2'd2,
        ROT_THREE_Q = 2'd3
    } crp_rot_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
        logic               frame_start;
    } crp_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] dest_index;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic [DIM_W-1:0]   out_width;
        logic [DIM_W-1:0]   out_height;
        logic               last_pixel;
    } crp_out_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [CNT_W-1:0] crop_top;
        logic [CNT_W-1:0] crop_left;
        logic [DIM_W-1:0] crop_bottom;
        logic [DIM_W-1:0] crop_right;
        crp_rot_t         rotation;
    } crp_cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [CNT_W-1:0]   col_ofs;
        logic [CNT_W-1:0]   row_ofs;
    } crp_pos_t;

endpackage

`default_nettype wire

@@ rtl/crp_position.sv @@
// ----------------------------------------------------------------------------
// crp_position
// Raster counters, crop window test and the input register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_position (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire crp_pkg::crp_cfg_t cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire crp_pkg::crp_in_t  in_data,
    output logic                   pos_valid,
    input  wire logic              pos_ready,
    output crp_pkg::crp_pos_t      pos_data
);

    logic [crp_pkg::CNT_W-1:0] col_reg, col_next;
    logic [crp_pkg::CNT_W-1:0] row_reg, row_next;
    logic                      valid_reg, valid_next;
    crp_pkg::crp_pos_t         data_reg, data_next;

    logic [crp_pkg::CNT_W-1:0] col, row;
    logic [crp_pkg::DIM_W-1:0] col_inc, row_inc;
    logic                      hit;
    logic                      accept;

    assign in_ready  = !valid_reg || pos_ready;
    assign accept    = in_valid && in_ready;
    assign pos_valid = valid_reg;
    assign pos_data  = data_reg;

    always_comb begin
        col = in_data.frame_start ? '0 : col_reg;
        row = in_data.frame_start ? '0 : row_reg;

        hit = (col >= cfg.crop_left) && ({1'b0, col} < cfg.crop_right) &&
              (row >= cfg.crop_top)  && ({1'b0, row} < cfg.crop_bottom);

        col_inc = {1'b0, col} + crp_pkg::DIM_W'(1);
        row_inc = {1'b0, row} + crp_pkg::DIM_W'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if ((col_inc >= cfg.frame_width) ||
                (col_inc >= crp_pkg::DIM_W'(crp_pkg::MAX_DIM))) begin
                col_next = '0;
                if ((row_inc >= cfg.frame_height) ||
                    (row_inc >= crp_pkg::DIM_W'(crp_pkg::MAX_DIM))) begin
                    row_next = '0;
                end else begin
                    row_next = row_inc[crp_pkg::CNT_W-1:0];
                end
            end else begin
                col_next = col_inc[crp_pkg::CNT_W-1:0];
                row_next = row;
            end
        end

        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = accept && hit;
        end
        if (accept) begin
            data_next.red     = in_data.red_in;
            data_next.green   = in_data.green_in;
            data_next.blue    = in_data.blue_in;
            data_next.col_ofs = col - cfg.crop_left;
            data_next.row_ofs = row - cfg.crop_top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ rtl/crp_address.sv @@
// ----------------------------------------------------------------------------
// crp_address
// Rotated destination index multiply-add and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_address (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire crp_pkg::crp_cfg_t cfg,
    input  wire logic              pos_valid,
    output logic                   pos_ready,
    input  wire crp_pkg::crp_pos_t pos_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output crp_pkg::crp_out_t      out_data
);

    logic               valid_reg, valid_next;
    crp_pkg::crp_out_t  data_reg, data_next;

    logic [crp_pkg::DIM_W-1:0]  ow, oh, i_ext, j_ext, i_rev, j_rev;
    logic [crp_pkg::DIM_W-1:0]  mul_a, mul_b, add_c;
    logic [crp_pkg::PROD_W-1:0] sum;

    assign pos_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        ow    = cfg.crop_right - {1'b0, cfg.crop_left};
        oh    = cfg.crop_bottom - {1'b0, cfg.crop_top};
        i_ext = {1'b0, pos_data.col_ofs};
        j_ext = {1'b0, pos_data.row_ofs};
        i_rev = ow - crp_pkg::DIM_W'(1) - i_ext;
        j_rev = oh - crp_pkg::DIM_W'(1) - j_ext;

        case (cfg.rotation)
            crp_pkg::ROT_QUARTER: begin
                mul_a = i_rev;
                mul_b = oh;
                add_c = j_ext;
            end
            crp_pkg::ROT_HALF: begin
                mul_a = j_rev;
                mul_b = ow;
                add_c = i_rev;
            end
            crp_pkg::ROT_THREE_Q: begin
                mul_a = i_ext;
                mul_b = oh;
                add_c = j_rev;
            end
            default: begin
                mul_a = j_ext;
                mul_b = ow;
                add_c = i_ext;
            end
        endcase

        sum = (crp_pkg::PROD_W'(mul_a) * crp_pkg::PROD_W'(mul_b)) +
              crp_pkg::PROD_W'(add_c);

        valid_next = valid_reg;
        data_next  = data_reg;
        if (pos_ready) begin
            valid_next = pos_valid;
            data_next.dest_index = sum[crp_pkg::INDEX_W-1:0];
            data_next.red_out    = pos_data.red;
            data_next.green_out  = pos_data.green;
            data_next.blue_out   = pos_data.blue;
            if (cfg.rotation == crp_pkg::ROT_QUARTER ||
                cfg.rotation == crp_pkg::ROT_THREE_Q) begin
                data_next.out_width  = oh;
                data_next.out_height = ow;
            end else begin
                data_next.out_width  = ow;
                data_next.out_height = oh;
            end
            data_next.last_pixel = (i_rev == '0) && (j_rev == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ rtl/crop_rotate_pixel_scatter.sv @@
// ----------------------------------------------------------------------------
// crop_rotate_pixel_scatter
// Crops a raster pixel stream and tags each kept pixel with its index in a
// rotated output frame buffer.
// ----------------------------------------------------------------------------
//   channel  direction  handshake               payload
//   s_       in         s_valid / s_ready       s_data   (crp_in_t)
//   m_       out        m_valid / m_ready       m_data   (crp_out_t)
//   cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one pixel per cycle when m_ is not stalled; a kept pixel reaches m_ through the
// input register and then the multiply-add result register
// pixels outside the crop window are dropped at the input register
// aresetn is synchronous; it clears counters, valids and loads register defaults
// each stage holds while its downstream is stalled, cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module crop_rotate_pixel_scatter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire crp_pkg::crp_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output crp_pkg::crp_out_t                        m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [crp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [crp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    crp_pkg::crp_cfg_t cfg_reg, cfg_next;
    logic              pos_valid, pos_ready;
    crp_pkg::crp_pos_t pos_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                crp_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width  = cfg_data[crp_pkg::DIM_W-1:0];
                crp_pkg::REG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg_data[crp_pkg::DIM_W-1:0];
                crp_pkg::REG_CROP_TOP:
                    cfg_next.crop_top     = cfg_data[crp_pkg::CNT_W-1:0];
                crp_pkg::REG_CROP_LEFT:
                    cfg_next.crop_left    = cfg_data[crp_pkg::CNT_W-1:0];
                crp_pkg::REG_CROP_BOTTOM:
                    cfg_next.crop_bottom  = cfg_data[crp_pkg::DIM_W-1:0];
                crp_pkg::REG_CROP_RIGHT:
                    cfg_next.crop_right   = cfg_data[crp_pkg::DIM_W-1:0];
                crp_pkg::REG_ROTATION:
                    cfg_next.rotation     = crp_pkg::crp_rot_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= crp_pkg::DIM_W'(320);
            cfg_reg.frame_height <= crp_pkg::DIM_W'(240);
            cfg_reg.crop_top     <= '0;
            cfg_reg.crop_left    <= '0;
            cfg_reg.crop_bottom  <= crp_pkg::DIM_W'(240);
            cfg_reg.crop_right   <= crp_pkg::DIM_W'(320);
            cfg_reg.rotation     <= crp_pkg::ROT_NONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    crp_position u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .pos_valid (pos_valid),
        .pos_ready (pos_ready),
        .pos_data  (pos_data)
    );

    crp_address u_address (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pos_valid (pos_valid),
        .pos_ready (pos_ready),
        .pos_data  (pos_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire
